@@ hw/rtl/awt_pkg.sv @@
// ----------------------------------------------------------------------------
// awt_pkg
// Shared widths, codes and types of the ACK window tracker and encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package awt_pkg;

    localparam int WINDOW_BITS_DEF = 64;
    localparam int MAX_RANGES_DEF  = 4;

    localparam int PN_W    = 62;
    localparam int TIME_W  = 63;
    localparam int KIND_W  = 2;
    localparam int FB_W    = 6;
    localparam int CNT_W   = 3;
    localparam int GB_W    = 6;
    localparam int EXP_W   = 5;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_HANDSHAKE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_EXP = 1'd1;

    localparam logic [EXP_W-1:0] DELAY_EXP_RESET = 5'd3;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd2;

    typedef struct packed {
        logic             handshake_complete;
        logic [EXP_W-1:0] delay_shift;
    } cfg_t;

    typedef struct packed {
        logic recv;
        logic capture;
        logic build;
        logic first;
        logic pair;
        logic load_hdr;
        logic load_pair;
    } ctl_t;

    typedef struct packed {
        logic none;
        logic pair_done;
        logic count_zero;
        logic emit_last;
        logic slot_free;
    } sts_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic              fast_ack_request;
        logic              rx_timer_reset;
        logic              nothing_received;
        logic [PN_W-1:0]   largest_acked;
        logic [PN_W-1:0]   ack_delay;
        logic [FB_W-1:0]   first_run;
        logic [CNT_W-1:0]  range_count;
        logic [GB_W-1:0]   gap_minus_one;
        logic [GB_W-1:0]   block_minus_one;
        logic              last;
    } row_t;

endpackage

`default_nettype wire

@@ hw/rtl/awt_req_if.sv @@
// ----------------------------------------------------------------------------
// awt_req_if
// Request channel: record a packet or generate ACK fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface awt_req_if;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [awt_pkg::PN_W-1:0]   packet_number;
    logic [awt_pkg::TIME_W-1:0] time_now;

    modport source (output valid, output mode, output packet_number, output time_now,
                    input ready);
    modport sink (input valid, input mode, input packet_number, input time_now,
                  output ready);

endinterface

`default_nettype wire

@@ hw/rtl/awt_res_if.sv @@
// ----------------------------------------------------------------------------
// awt_res_if
// Result channel: receive status, ACK header and gap/block pair items.
// ----------------------------------------------------------------------------
`default_nettype none

interface awt_res_if;

    logic                      valid;
    logic                      ready;
    logic [awt_pkg::KIND_W-1:0] result_kind;
    logic                      fast_ack_request;
    logic                      rx_timer_reset;
    logic                      nothing_received;
    logic [awt_pkg::PN_W-1:0]   largest_acked;
    logic [awt_pkg::PN_W-1:0]   ack_delay;
    logic [awt_pkg::FB_W-1:0]   first_run;
    logic [awt_pkg::CNT_W-1:0]  range_count;
    logic [awt_pkg::GB_W-1:0]   gap_minus_one;
    logic [awt_pkg::GB_W-1:0]   block_minus_one;
    logic                      last;

    modport source (output valid, output result_kind, output fast_ack_request,
                    output rx_timer_reset, output nothing_received, output largest_acked,
                    output ack_delay, output first_run, output range_count,
                    output gap_minus_one, output block_minus_one, output last,
                    input ready);
    modport sink (input valid, input result_kind, input fast_ack_request,
                  input rx_timer_reset, input nothing_received, input largest_acked,
                  input ack_delay, input first_run, input range_count,
                  input gap_minus_one, input block_minus_one, input last,
                  output ready);

endinterface

`default_nettype wire

@@ hw/rtl/awt_cfg.sv @@
// ----------------------------------------------------------------------------
// awt_cfg
// APB register file: handshake_complete and delay_shift.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [awt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [awt_pkg::DATA_W-1:0]  pwdata,
    output logic      [awt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output awt_pkg::cfg_t                    cfg
);

    logic                              hs_reg;
    logic                              hs_next;
    logic [awt_pkg::EXP_W-1:0]         exp_reg;
    logic [awt_pkg::EXP_W-1:0]         exp_next;
    logic [awt_pkg::REG_IDX_W-1:0]     idx;
    logic                              wr;

    assign pready = 1'b1;
    assign idx    = paddr[awt_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        hs_next  = hs_reg;
        exp_next = exp_reg;
        if (wr)
        begin
            unique case (idx)
                awt_pkg::REG_HANDSHAKE: hs_next  = pwdata[0];
                awt_pkg::REG_DELAY_EXP: exp_next = pwdata[awt_pkg::EXP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            awt_pkg::REG_HANDSHAKE: prdata = awt_pkg::DATA_W'(hs_reg);
            awt_pkg::REG_DELAY_EXP: prdata = awt_pkg::DATA_W'(exp_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg  <= 1'b0;
            exp_reg <= awt_pkg::DELAY_EXP_RESET;
        end
        else
        begin
            hs_reg  <= hs_next;
            exp_reg <= exp_next;
        end
    end

    assign cfg.handshake_complete = hs_reg;
    assign cfg.delay_shift        = exp_reg;

endmodule

`default_nettype wire

@@ hw/rtl/awt_ctrl.sv @@
// ----------------------------------------------------------------------------
// awt_ctrl
// Sequencer: accept requests, step the bitmap walk, emit result items.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_mode,
    output logic               req_ready,
    input  wire awt_pkg::sts_t sts,
    output awt_pkg::ctl_t      ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BUILD = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_PAIR  = 3'd3;
    localparam logic [2:0] S_HDR   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE) && sts.slot_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_mode)
                    begin
                        ctl.capture = 1'b1;
                        state_next  = S_BUILD;
                    end
                    else
                    begin
                        ctl.recv = 1'b1;
                    end
                end
            end
            S_BUILD:
            begin
                ctl.build  = 1'b1;
                state_next = sts.none ? S_HDR : S_FIRST;
            end
            S_FIRST:
            begin
                ctl.first  = 1'b1;
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                if (sts.pair_done)
                begin
                    state_next = S_HDR;
                end
                else
                begin
                    ctl.pair = 1'b1;
                end
            end
            S_HDR:
            begin
                if (sts.slot_free)
                begin
                    ctl.load_hdr = 1'b1;
                    state_next   = sts.count_zero ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    ctl.load_pair = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/awt_dp.sv @@
// ----------------------------------------------------------------------------
// awt_dp
// Datapath: window state, bitmap walk registers, pair buffer, output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_dp #(
    parameter int WINDOW_BITS = awt_pkg::WINDOW_BITS_DEF,
    parameter int MAX_RANGES  = awt_pkg::MAX_RANGES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [awt_pkg::PN_W-1:0]    packet_number,
    input  wire logic [awt_pkg::TIME_W-1:0]  time_now,
    input  wire awt_pkg::cfg_t               cfg,
    input  wire awt_pkg::ctl_t               ctl,
    output awt_pkg::sts_t                    sts,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output awt_pkg::row_t                    out_row
);

    localparam int IW  = $clog2(WINDOW_BITS);
    localparam int NB  = WINDOW_BITS - 1;
    localparam int CW  = $clog2(MAX_RANGES + 1);
    localparam int PIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int PW  = awt_pkg::PN_W;
    localparam int TW  = awt_pkg::TIME_W;

    function automatic logic [IW-1:0] ctz(input logic [WINDOW_BITS-1:0] x);
        logic [IW-1:0] r;
        r = '0;
        for (int i = WINDOW_BITS - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    logic [PW-1:0]          nx_reg;
    logic [WINDOW_BITS-1:0] map_reg;
    logic [TW-1:0]          newest_reg;
    logic                   out_valid_reg;

    logic [TW-1:0]          now_reg;
    logic [TW-1:0]          tdiff_reg;
    logic [NB-1:0]          walk_reg;
    logic [IW-1:0]          first_reg;
    logic [PW-1:0]          delay_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          rd_idx_reg;
    logic [awt_pkg::GB_W-1:0] gap_mem [MAX_RANGES];
    logic [awt_pkg::GB_W-1:0] blk_mem [MAX_RANGES];
    awt_pkg::row_t          row_reg;
    awt_pkg::row_t          row_next;

    // receive path
    logic [PW:0]            nx_ext;
    logic [PW:0]            num_ext;
    logic                   top_pn;
    logic                   stale;
    logic                   take;
    logic                   ahead;
    logic                   at_or_ahead;
    logic                   far;
    logic [PW-1:0]          diff;
    logic [WINDOW_BITS-1:0] thermo;
    logic [2*WINDOW_BITS-1:0] rot_clr;
    logic [WINDOW_BITS-1:0] clr;
    logic [WINDOW_BITS-1:0] setbit;
    logic                   fast;
    logic                   timer;

    // walk build
    logic [PW-1:0]          largest;
    logic [IW-1:0]          rot_amt;
    logic [WINDOW_BITS-1:0] rev;
    logic [2*WINDOW_BITS-1:0] rot_walk;
    logic [NB-1:0]          vmask;
    logic [TW-1:0]          tdiff;
    logic [TW-1:0]          dshift;

    // run search
    logic [WINDOW_BITS-1:0] vext;
    logic [WINDOW_BITS-1:0] lowb;
    logic [WINDOW_BITS-1:0] run_end;
    logic [IW-1:0]          e_first;
    logic [IW-1:0]          g_pos;
    logic [IW-1:0]          e_pos;

    always_comb
    begin
        nx_ext      = {1'b0, nx_reg};
        num_ext     = {1'b0, packet_number};
        top_pn      = &packet_number;
        stale       = (nx_ext >= (PW+1)'(WINDOW_BITS)) &&
                      (num_ext < nx_ext - (PW+1)'(WINDOW_BITS));
        take        = !top_pn && !stale;
        ahead       = packet_number > nx_reg;
        at_or_ahead = packet_number >= nx_reg;
        far         = num_ext >= nx_ext + (PW+1)'(WINDOW_BITS);
        diff        = packet_number - nx_reg;
        thermo      = ~({WINDOW_BITS{1'b1}} << diff[IW-1:0]);
        rot_clr     = {thermo, thermo} << nx_reg[IW-1:0];
        if (far)
        begin
            clr = '1;
        end
        else if (ahead)
        begin
            clr = rot_clr[2*WINDOW_BITS-1:WINDOW_BITS];
        end
        else
        begin
            clr = '0;
        end
        setbit = WINDOW_BITS'(1) << packet_number[IW-1:0];
        fast   = take && ahead && cfg.handshake_complete;
        timer  = take && at_or_ahead;
    end

    always_comb
    begin
        largest = nx_reg - PW'(1);
        rot_amt = ~(nx_reg[IW-1:0] - IW'(2));
        for (int j = 0; j < WINDOW_BITS; j++)
        begin
            rev[j] = map_reg[WINDOW_BITS-1-j];
        end
        rot_walk = {rev, rev} >> rot_amt;
        if (largest >= PW'(NB))
        begin
            vmask = '1;
        end
        else
        begin
            vmask = ~({NB{1'b1}} << largest[IW-1:0]);
        end
        tdiff  = (now_reg >= newest_reg) ? (now_reg - newest_reg) : '0;
        dshift = tdiff_reg >> cfg.delay_shift;
    end

    always_comb
    begin
        vext    = {1'b0, walk_reg};
        lowb    = vext & (~vext + WINDOW_BITS'(1));
        run_end = vext + lowb;
        e_first = ctz(vext + WINDOW_BITS'(1));
        g_pos   = ctz(vext);
        e_pos   = ctz(run_end);
    end

    always_comb
    begin
        row_next = row_reg;
        if (ctl.recv)
        begin
            row_next                  = '0;
            row_next.result_kind      = awt_pkg::KIND_STATUS;
            row_next.fast_ack_request = fast;
            row_next.rx_timer_reset   = timer;
            row_next.last             = 1'b1;
        end
        else if (ctl.load_hdr)
        begin
            row_next             = '0;
            row_next.result_kind = awt_pkg::KIND_HEADER;
            if (nx_reg == '0)
            begin
                row_next.nothing_received = 1'b1;
                row_next.last             = 1'b1;
            end
            else
            begin
                row_next.largest_acked = largest;
                row_next.ack_delay     = delay_reg;
                row_next.first_run     = awt_pkg::FB_W'(first_reg);
                row_next.range_count   = awt_pkg::CNT_W'(count_reg);
                row_next.last          = (count_reg == '0);
            end
        end
        else if (ctl.load_pair)
        begin
            row_next                 = '0;
            row_next.result_kind     = awt_pkg::KIND_PAIR;
            row_next.gap_minus_one   = gap_mem[rd_idx_reg[PIW-1:0]];
            row_next.block_minus_one = blk_mem[rd_idx_reg[PIW-1:0]];
            row_next.last            = (CW'(rd_idx_reg + CW'(1)) == count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg        <= '0;
            map_reg       <= '0;
            newest_reg    <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (ctl.recv && take)
            begin
                map_reg <= (map_reg & ~clr) | setbit;
                if (at_or_ahead)
                begin
                    nx_reg     <= packet_number + PW'(1);
                    newest_reg <= time_now;
                end
            end
            if (ctl.capture)
            begin
                count_reg <= '0;
            end
            else if (ctl.pair)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (ctl.load_hdr)
            begin
                rd_idx_reg <= '0;
            end
            else if (ctl.load_pair)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            if (ctl.recv || ctl.load_hdr || ctl.load_pair)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            now_reg <= time_now;
        end
        if (ctl.build)
        begin
            walk_reg  <= rot_walk[NB-1:0] & vmask;
            tdiff_reg <= tdiff;
        end
        if (ctl.first)
        begin
            first_reg <= e_first;
            walk_reg  <= walk_reg >> e_first;
            delay_reg <= dshift[TW-1] ? {PW{1'b1}} : dshift[PW-1:0];
        end
        if (ctl.pair)
        begin
            gap_mem[count_reg[PIW-1:0]] <= awt_pkg::GB_W'(g_pos - IW'(1));
            blk_mem[count_reg[PIW-1:0]] <= awt_pkg::GB_W'(e_pos - g_pos - IW'(1));
            walk_reg <= walk_reg >> e_pos;
        end
        row_reg <= row_next;
    end

    assign sts.none       = (nx_reg == '0);
    assign sts.pair_done  = (walk_reg == '0) || (count_reg == CW'(MAX_RANGES));
    assign sts.count_zero = (count_reg == '0);
    assign sts.emit_last  = (CW'(rd_idx_reg + CW'(1)) == count_reg);
    assign sts.slot_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ack_window_tracker_encoder.sv @@
// ----------------------------------------------------------------------------
// ack_window_tracker_encoder
// Receive window bitmap tracker with ACK header and range field encoder.
// ----------------------------------------------------------------------------
// request carries mode, packet_number and time_now. Mode 0 records a packet
// and returns one registered status item in the cycle after acceptance; a
// new item is taken every cycle while result is drained. Mode 1 returns an
// ACK header and up to MAX_RANGES gap/block pair items: the walk aligns the
// bitmap, finds the first run, then finds the pairs one by one until the
// walk ends or MAX_RANGES is reached, then loads the header and each pair
// item into the output register as it frees; the next request is taken once
// the last item is loaded and the output register is free.
// An empty window skips the run search: its single header follows the build.
// One request is in work at a time; the sequencer and result back-pressure
// set the rate. result is a single output register: a stalled result holds
// its item and request stays not ready until the register can be refilled.
// Via the APB port the user sets handshake_complete (0x0) and delay_shift
// (0x4) only while idle, not enforced by the block. pready is always high.
// Reset clears the window, the newest arrival time and the output valid flag,
// and loads the register defaults. WINDOW_BITS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_window_tracker_encoder #(
    parameter int WINDOW_BITS = awt_pkg::WINDOW_BITS_DEF,
    parameter int MAX_RANGES  = awt_pkg::MAX_RANGES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    awt_req_if.sink                          request,
    awt_res_if.source                        result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [awt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [awt_pkg::DATA_W-1:0]  pwdata,
    output logic      [awt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    awt_pkg::cfg_t cfg;
    awt_pkg::ctl_t ctl;
    awt_pkg::sts_t sts;
    awt_pkg::row_t row;
    logic          req_ready;
    logic          out_valid;

    awt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    awt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_mode  (request.mode),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    awt_dp #(
        .WINDOW_BITS (WINDOW_BITS),
        .MAX_RANGES  (MAX_RANGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .packet_number (request.packet_number),
        .time_now      (request.time_now),
        .cfg           (cfg),
        .ctl           (ctl),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (result.ready),
        .out_row       (row)
    );

    assign request.ready           = req_ready;
    assign result.valid            = out_valid;
    assign result.result_kind      = row.result_kind;
    assign result.fast_ack_request = row.fast_ack_request;
    assign result.rx_timer_reset   = row.rx_timer_reset;
    assign result.nothing_received = row.nothing_received;
    assign result.largest_acked    = row.largest_acked;
    assign result.ack_delay        = row.ack_delay;
    assign result.first_run        = row.first_run;
    assign result.range_count      = row.range_count;
    assign result.gap_minus_one    = row.gap_minus_one;
    assign result.block_minus_one  = row.block_minus_one;
    assign result.last             = row.last;

endmodule

`default_nettype wire
